// File: rtl/ldp_pkg.sv
// Shared types and constants for the LZ bitstream depacker.
package ldp_pkg;

  // Kind of word held in the front queue
  typedef enum logic {
    K_WORD = 1'b0,  // packed stream word supplied
    K_REQ  = 1'b1   // next output byte requested
  } kind_t;

  // Queue entry passed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [15:0] word;
  } item_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Bitstream decode phase
  typedef enum logic [2:0] {
    PH_FLAG     = 3'd0,
    PH_LITLEN   = 3'd1,
    PH_LIT      = 3'd2,
    PH_CODE     = 3'd3,
    PH_OFFSET   = 3'd4,
    PH_MATCHLEN = 3'd5,
    PH_COPY     = 3'd6
  } phase_t;

  // Back-end sequencer state
  typedef enum logic [1:0] {
    C_IDLE = 2'd0,
    C_RUN  = 2'd1,
    C_READ = 2'd2
  } ctl_t;

  // Register indexes on the config port
  localparam logic REG_TABLE = 1'b0;
  localparam logic REG_SIZE  = 1'b1;

  localparam logic [1:0] LITLEN_CONT   = 2'd3;
  localparam logic [2:0] MATCHLEN_CONT = 3'd7;
  localparam logic [4:0] MAX_OFS_BITS  = 5'd16;
  localparam logic [15:0] MATCHLEN_ADD = 16'd4;

endpackage

// File: rtl/ldp_if.sv
// Channel interfaces for input words and result words.
interface ldp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] packed_word;
  modport source (output valid, output operation, output packed_word, input ready);
  modport sink (input valid, input operation, input packed_word, output ready);
endinterface

interface ldp_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       need_word;
  logic       done_res;
  modport source (output valid, output byte_valid, output out_byte, output need_word,
                  output done_res, input ready);
  modport sink (input valid, input byte_valid, input out_byte, input need_word,
                input done_res, output ready);
endinterface

// File: rtl/ldp_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module ldp_front
  import ldp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ldp_in_if.sink     in_ch,
  output q_head_t    q_head,
  input  logic       q_pop
);

  item_t       q_mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  item_t       cls_item;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;

  // Classify the incoming word
  assign cls_item.kind = in_ch.operation ? K_REQ : K_WORD;
  assign cls_item.word = in_ch.packed_word;

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (q_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

// File: rtl/ldp_back.sv
// Back end: bit buffer, field parser, history memory and result register.
module ldp_back
  import ldp_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_head_t     q_head,
  output logic        q_pop,
  input  logic [63:0] ofs_table,
  input  logic [23:0] out_size,
  ldp_out_if.source   out_ch
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [16:0] DEPTH17 = 17'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

  logic [7:0]  hist_mem [HISTORY_DEPTH];

  ctl_t        ctl_r, ctl_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] buf_r, buf_nxt;
  logic [5:0]  avail_r, avail_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [2:0]  code_r, code_nxt;
  logic [16:0] dm_r, dm_nxt;
  logic [23:0] prod_r, prod_nxt;
  logic [AW-1:0] wp_r, wp_nxt;

  logic        ov_r, ov_nxt;
  logic        bv_r, bv_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        nw_r, nw_nxt;
  logic        dn_r, dn_nxt;

  logic [7:0]  rdata_r;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [7:0]  wr_data;

  logic [4:0]  need_n;
  logic [7:0]  tbl_byte;
  logic [4:0]  ofs_w;
  logic        take_ok;
  logic [5:0]  left_n;
  logic [31:0] shifted;
  logic [15:0] take_val;
  logic [31:0] keep_mask;
  logic [23:0] prod_inc;
  logic        done_now;
  logic        slot_free;
  logic [16:0] wp_x;
  logic [16:0] idx_x;

  // Offset width from the table, clamped
  assign tbl_byte = ofs_table[{code_r, 3'b000} +: 8];
  assign ofs_w    = (tbl_byte > 8'(MAX_OFS_BITS)) ? MAX_OFS_BITS : tbl_byte[4:0];

  // Field width per phase
  always_comb begin
    unique case (phase_r)
      PH_FLAG:     need_n = 5'd1;
      PH_LITLEN:   need_n = 5'd2;
      PH_LIT:      need_n = 5'd8;
      PH_CODE:     need_n = 5'd3;
      PH_OFFSET:   need_n = ofs_w;
      PH_MATCHLEN: need_n = 5'd3;
      default:     need_n = 5'd0;
    endcase
  end

  // Extract the top need_n valid bits
  assign take_ok   = (avail_r >= 6'(need_n));
  assign left_n    = avail_r - 6'(need_n);
  assign shifted   = buf_r >> left_n;
  assign take_val  = shifted[15:0] & 16'((17'd1 << need_n) - 17'd1);
  assign keep_mask = 32'((33'd1 << left_n) - 33'd1);

  assign prod_inc  = prod_r + 24'd1;
  assign done_now  = (prod_r >= out_size);
  assign slot_free = !ov_r || out_ch.ready;

  // Copy source address
  assign wp_x  = 17'(wp_r);
  assign idx_x = (wp_x >= dm_r) ? (wp_x - dm_r) : (wp_x + DEPTH17 - dm_r);
  assign rd_addr = idx_x[AW-1:0];

  always_comb begin
    ctl_nxt   = ctl_r;
    phase_nxt = phase_r;
    buf_nxt   = buf_r;
    avail_nxt = avail_r;
    rem_nxt   = rem_r;
    code_nxt  = code_r;
    dm_nxt    = dm_r;
    prod_nxt  = prod_r;
    wp_nxt    = wp_r;
    ov_nxt    = ov_r;
    bv_nxt    = bv_r;
    ob_nxt    = ob_r;
    nw_nxt    = nw_r;
    dn_nxt    = dn_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_data   = 8'd0;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (ctl_r)
      C_IDLE: begin
        if (q_head.valid && slot_free) begin
          q_pop = 1'b1;
          if (q_head.item.kind == K_WORD) begin
            if (avail_r <= 6'd16) begin
              buf_nxt   = {buf_r[15:0], q_head.item.word};
              avail_nxt = avail_r + 6'd16;
            end
            ov_nxt = 1'b1;
            bv_nxt = 1'b0;
            ob_nxt = 8'd0;
            nw_nxt = 1'b0;
            dn_nxt = done_now;
          end else if (done_now) begin
            ov_nxt = 1'b1;
            bv_nxt = 1'b0;
            ob_nxt = 8'd0;
            nw_nxt = 1'b0;
            dn_nxt = 1'b1;
          end else begin
            ctl_nxt = C_RUN;
          end
        end
      end
      C_RUN: begin
        if (phase_r == PH_COPY) begin
          // reduce the distance modulo the history depth, then read
          if (dm_r >= DEPTH17) begin
            dm_nxt = dm_r - DEPTH17;
          end else begin
            rd_en   = 1'b1;
            ctl_nxt = C_READ;
          end
        end else if (!take_ok) begin
          // stall: out of stream bits
          ov_nxt  = 1'b1;
          bv_nxt  = 1'b0;
          ob_nxt  = 8'd0;
          nw_nxt  = 1'b1;
          dn_nxt  = 1'b0;
          ctl_nxt = C_IDLE;
        end else begin
          buf_nxt   = buf_r & keep_mask;
          avail_nxt = left_n;
          unique case (phase_r)
            PH_FLAG: begin
              if (take_val[0]) begin
                rem_nxt   = 16'd0;
                phase_nxt = PH_LITLEN;
              end else begin
                phase_nxt = PH_CODE;
              end
            end
            PH_LITLEN: begin
              rem_nxt = rem_r + 16'(take_val[1:0]);
              if (take_val[1:0] != LITLEN_CONT) begin
                phase_nxt = PH_LIT;
              end
            end
            PH_LIT: begin
              if (rem_r == 16'd0) begin
                phase_nxt = (prod_inc >= out_size) ? PH_FLAG : PH_CODE;
              end else begin
                rem_nxt = rem_r - 16'd1;
              end
              wr_en   = 1'b1;
              wr_data = take_val[7:0];
              ctl_nxt = C_IDLE;
            end
            PH_CODE: begin
              code_nxt  = take_val[2:0];
              phase_nxt = PH_OFFSET;
            end
            PH_OFFSET: begin
              dm_nxt = 17'(take_val) + 17'd1;
              if (code_r[1:0] != 2'd0) begin
                rem_nxt   = 16'(code_r[1:0]);
                phase_nxt = PH_COPY;
              end else begin
                rem_nxt   = 16'd0;
                phase_nxt = PH_MATCHLEN;
              end
            end
            PH_MATCHLEN: begin
              if (take_val[2:0] != MATCHLEN_CONT) begin
                rem_nxt   = rem_r + 16'(take_val[2:0]) + MATCHLEN_ADD;
                phase_nxt = PH_COPY;
              end else begin
                rem_nxt = rem_r + 16'(take_val[2:0]);
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
      C_READ: begin
        if (rem_r == 16'd0) begin
          phase_nxt = PH_FLAG;
        end else begin
          rem_nxt = rem_r - 16'd1;
        end
        wr_en   = 1'b1;
        wr_data = rdata_r;
        ctl_nxt = C_IDLE;
      end
      default: begin
        ctl_nxt = C_IDLE;
      end
    endcase

    // Emit a decoded byte
    if (wr_en) begin
      prod_nxt = prod_inc;
      if (prod_inc == 24'd0 || wp_r == WP_LAST) begin
        wp_nxt = '0;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
      ov_nxt = 1'b1;
      bv_nxt = 1'b1;
      ob_nxt = wr_data;
      nw_nxt = 1'b0;
      dn_nxt = (prod_inc >= out_size);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= C_IDLE;
      phase_r <= PH_FLAG;
      buf_r   <= '0;
      avail_r <= '0;
      rem_r   <= '0;
      code_r  <= '0;
      dm_r    <= '0;
      prod_r  <= '0;
      wp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      ctl_r   <= ctl_nxt;
      phase_r <= phase_nxt;
      buf_r   <= buf_nxt;
      avail_r <= avail_nxt;
      rem_r   <= rem_nxt;
      code_r  <= code_nxt;
      dm_r    <= dm_nxt;
      prod_r  <= prod_nxt;
      wp_r    <= wp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    bv_r <= bv_nxt;
    ob_r <= ob_nxt;
    nw_r <= nw_nxt;
    dn_r <= dn_nxt;
  end

  // History memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wp_r] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= hist_mem[rd_addr];
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.byte_valid = bv_r;
  assign out_ch.out_byte   = ob_r;
  assign out_ch.need_word  = nw_r;
  assign out_ch.done_res   = dn_r;

endmodule

// File: rtl/lz_bitstream_depacker.sv
// Top level: config registers and the front/back decoder pair.
//
//  channel  | direction | words carried
//  ---------+-----------+----------------------------------------------
//  in_ch    | in        | operation, packed_word
//  out_ch   | out       | byte_valid, out_byte, need_word, done_res
//  cfg_*    | in/out    | APB register writes and reads (64-bit data)
//
// A supplied word or a finished request passes the queue, then the back end's result register.
// A request parses one field per cycle while stream bits last, a literal is emitted
// on its field's cycle, and a copied byte waits for the registered history memory read.
// Reset is synchronous, active low; the history memory is not cleared.
// A two-entry queue lets input words land while the result register is stalled.
module lz_bitstream_depacker
  import ldp_pkg::*;
#(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  ldp_in_if.sink      in_ch,
  ldp_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [63:0] table_r;
  logic [23:0] size_r;
  logic        cfg_wr;
  q_head_t     q_head;
  logic        q_pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_r <= '0;
      size_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        REG_TABLE: table_r <= cfg_pwdata;
        REG_SIZE:  size_r  <= cfg_pwdata[23:0];
        default:   table_r <= table_r;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == REG_SIZE) ? {40'd0, size_r} : table_r;

  ldp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  ldp_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .ofs_table (table_r),
    .out_size  (size_r),
    .out_ch    (out_ch)
  );

endmodule
